// ----- src/cpli_pkg.sv -----
// ----------------------------------------------------------------------------
// cpli_pkg: shared types and constants
// Coordinate widths, the sequencer states and the divider request/response
// structs used by the closed path interpolator.
// ----------------------------------------------------------------------------
package cpli_pkg;

  localparam int COORD_W   = 32;           // signed q16.16 coordinate
  localparam int MAG_W     = COORD_W + 1;  // magnitude of a coordinate difference
  localparam int STEP_W    = 6;            // segment_steps register width
  localparam int MAX_STEPS = 32;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } cpli_state_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  dividend;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MAG_W-1:0]  quot;
    logic [STEP_W-1:0] rem;
  } div_rsp_t;

  // zero counts as one, large values clamp to the maximum
  function automatic logic [STEP_W-1:0] eff_steps(input logic [STEP_W-1:0] v);
    logic [STEP_W-1:0] n;
    n = v;
    if (v == '0) begin
      n = STEP_W'(1);
    end else if (v > STEP_W'(MAX_STEPS)) begin
      n = STEP_W'(MAX_STEPS);
    end
    return n;
  endfunction

endpackage

// ----- src/cpli_divider.sv -----
// ----------------------------------------------------------------------------
// cpli_divider: radix-2 restoring divider
// Divides an unsigned magnitude by a small step count, one quotient bit
// per cycle; done pulses once quotient and remainder are valid.
// ----------------------------------------------------------------------------
module cpli_divider (
  input  logic               clk,
  input  logic               rst,
  input  cpli_pkg::div_req_t req,
  output cpli_pkg::div_rsp_t rsp
);
  import cpli_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  dq;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] divisor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial = {rem, dq[MAG_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dq  <= {dq[MAG_W-2:0], fits};
      rem <= fits ? STEP_W'(trial - {1'b0, divisor}) : trial[STEP_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dq;
  assign rsp.rem  = rem;

endmodule

// ----- src/closed_path_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// closed_path_linear_interpolator: waypoint stream to evenly spaced points
// Emits segment_steps points per path segment (zero as one, clamped to 32),
// closing the loop to the first waypoint on the final one; one shared divider sets up each segment.
// ----------------------------------------------------------------------------
// sequence: a non-final first waypoint is only absorbed; every other
//   waypoint runs 1 or 2 segments, each with divider setup
//   (33 quotient bits per axis, x/y/z in turn) before its n points
// throughput: one point per cycle while emitting unless out_ready stalls; between segments the single divider bounds it
// reset: synchronous, clears the open path, the points and segment_steps=8
// ----------------------------------------------------------------------------
module closed_path_linear_interpolator (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [cpli_pkg::STEP_W-1:0]          cfg_wr_data,
  // waypoint input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cpli_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [cpli_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [cpli_pkg::COORD_W-1:0]  pos_z,
  input  logic                                 is_final,
  // point output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cpli_pkg::COORD_W-1:0]  out_x,
  output logic signed [cpli_pkg::COORD_W-1:0]  out_y,
  output logic signed [cpli_pkg::COORD_W-1:0]  out_z,
  output logic                                 run_end
);
  import cpli_pkg::*;

  // configuration register
  logic [STEP_W-1:0] segment_steps;

  // path state
  logic signed [COORD_W-1:0] first_point [3];
  logic signed [COORD_W-1:0] prev_point  [3];
  logic                      have_prev;

  // current segment endpoints
  logic signed [COORD_W-1:0] seg_start [3];
  logic signed [COORD_W-1:0] seg_end   [3];
  logic                      close_pending;  // closing segment still to run
  logic                      last_seg;       // this segment ends the item

  // step setup per axis: |diff| = qd * n + rd
  logic [MAG_W-1:0]  qd  [3];
  logic [STEP_W-1:0] rd  [3];
  logic              neg [3];

  // running quotient/remainder of |diff| * s / n per axis
  logic [MAG_W-1:0]  acc_q      [3];
  logic [STEP_W-1:0] acc_r      [3];
  logic [MAG_W-1:0]  acc_q_next [3];
  logic [STEP_W-1:0] acc_r_next [3];
  logic signed [COORD_W-1:0] point [3];

  logic [STEP_W-1:0] n_cur;
  logic [IDX_W-1:0]  s_cnt;
  logic [1:0]        axis;
  logic              s_last;

  cpli_state_t state, state_next;
  logic        in_xfer;
  logic        out_xfer;
  logic        emit_load;  // next point goes into the output register

  div_req_t div_req;
  div_rsp_t div_rsp;

  // difference on the axis being set up
  logic signed [MAG_W-1:0] diff;
  logic        [MAG_W-1:0] diff_mag;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign s_last   = ({1'b0, s_cnt} == n_cur - STEP_W'(1));

  assign diff     = MAG_W'(seg_end[axis]) - MAG_W'(seg_start[axis]);
  assign diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  assign div_req.start    = (state == ST_DIV_GO);
  assign div_req.dividend = diff_mag;
  assign div_req.divisor  = n_cur;

  cpli_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // per axis lanes: advance s by one and form the current point
  always_comb begin
    logic [STEP_W:0]    r_sum;
    logic [COORD_W+1:0] offs;
    logic [COORD_W+1:0] sum;
    for (int c = 0; c < 3; c++) begin
      r_sum = {1'b0, acc_r[c]} + {1'b0, rd[c]};
      if (r_sum >= {1'b0, n_cur}) begin
        acc_r_next[c] = STEP_W'(r_sum - {1'b0, n_cur});
        acc_q_next[c] = acc_q[c] + qd[c] + MAG_W'(1);
      end else begin
        acc_r_next[c] = r_sum[STEP_W-1:0];
        acc_q_next[c] = acc_q[c] + qd[c];
      end
      offs     = neg[c] ? -{1'b0, acc_q[c]} : {1'b0, acc_q[c]};
      sum      = {{2{seg_start[c][COORD_W-1]}}, seg_start[c]} + offs;
      point[c] = sum[COORD_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && (have_prev || is_final)) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (axis == 2'd2) ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        emit_load = !out_valid || out_ready;
        if (emit_load && s_last) begin
          state_next = close_pending ? ST_DIV_GO : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_steps <= STEPS_RESET;
      have_prev     <= 1'b0;
      close_pending <= 1'b0;
      last_seg      <= 1'b0;
      out_valid     <= 1'b0;
      axis          <= '0;
      s_cnt         <= '0;
      n_cur         <= STEP_W'(1);
    end else begin
      if (cfg_wr_en) begin
        segment_steps <= cfg_wr_data;
      end
      if (in_xfer) begin
        n_cur <= eff_steps(segment_steps);
        axis  <= '0;
        if (!have_prev) begin
          // lone final waypoint runs only the closing segment onto itself
          have_prev     <= !is_final;
          close_pending <= 1'b0;
          last_seg      <= 1'b1;
        end else begin
          have_prev     <= !is_final;
          close_pending <= is_final;
          last_seg      <= !is_final;
        end
      end
      if (state == ST_DIV_WAIT && div_rsp.done) begin
        axis  <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        s_cnt <= '0;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
        s_cnt     <= s_cnt + IDX_W'(1);
        if (s_last && close_pending) begin
          close_pending <= 1'b0;
          last_seg      <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // path points
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        first_point[c] <= '0;
        prev_point[c]  <= '0;
      end
    end else if (in_xfer) begin
      prev_point[0] <= pos_x;
      prev_point[1] <= pos_y;
      prev_point[2] <= pos_z;
      if (!have_prev) begin
        first_point[0] <= pos_x;
        first_point[1] <= pos_y;
        first_point[2] <= pos_z;
      end
    end
  end

  // segment endpoints and per axis step terms
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      seg_end[0] <= pos_x;
      seg_end[1] <= pos_y;
      seg_end[2] <= pos_z;
      if (have_prev) begin
        for (int c = 0; c < 3; c++) begin
          seg_start[c] <= prev_point[c];
        end
      end else begin
        seg_start[0] <= pos_x;
        seg_start[1] <= pos_y;
        seg_start[2] <= pos_z;
      end
    end else if (emit_load && s_last && close_pending) begin
      // closing segment: from this waypoint back to the first one
      for (int c = 0; c < 3; c++) begin
        seg_start[c] <= prev_point[c];
        seg_end[c]   <= first_point[c];
      end
    end
    if (state == ST_DIV_WAIT && div_rsp.done) begin
      qd[axis]    <= div_rsp.quot;
      rd[axis]    <= div_rsp.rem;
      neg[axis]   <= diff[MAG_W-1];
      acc_q[axis] <= '0;
      acc_r[axis] <= '0;
    end
    if (emit_load) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q_next[c];
        acc_r[c] <= acc_r_next[c];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_x   <= point[0];
      out_y   <= point[1];
      out_z   <= point[2];
      run_end <= last_seg && s_last;
    end
  end

  // divider answers only while the sequencer waits on it
  a_div_done_waiting : assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV_WAIT)
    else $error("divider done outside of setup wait");

  // remainders stay below the step count while emitting
  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> acc_r[0] < n_cur && acc_r[1] < n_cur && acc_r[2] < n_cur)
    else $error("step remainder out of range");

  // the last point of the item returns the sequencer to idle
  a_end_to_idle : assert property (@(posedge clk) disable iff (rst)
    emit_load && last_seg && s_last |=> state == ST_IDLE)
    else $error("sequencer kept running after the last point");

  // latched step count stays in its legal range
  a_n_range : assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> n_cur != '0 && n_cur <= STEP_W'(MAX_STEPS))
    else $error("latched step count out of range");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: closed path linear interpolator
// Streams waypoint paths through the interpolator under random stalls on both
// sides and compares every emitted point against a local path predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpli_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   run_end;
  } point_t;

  // directed script rows: a waypoint transfer or a step count write
  typedef enum logic [0:0] {
    ROW_POINT,
    ROW_STEPS
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [STEP_W-1:0] steps;
    vec_t              pos;
    logic              fin;
    bit                fixed;     // expected coordinates typed in below
    vec_t              fixed_pt;  // every point of this waypoint equals this
  } row_t;

  localparam coord_t CMAX        = 32'sh7fff_ffff;
  localparam coord_t CMIN        = 32'sh8000_0000;
  localparam int     IDLE_PAD    = 8;        // quiet cycles before a step count write
  localparam int     END_PAD     = 40;       // quiet cycles after the last point
  localparam int     HOLD_CYCLES = 800;      // long receiver hold-off
  localparam int     LIMIT       = 4000000;  // watchdog, in clock cycles
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 50;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [STEP_W-1:0]          cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  coord_t                     pos_x;
  coord_t                     pos_y;
  coord_t                     pos_z;
  logic                       is_final;
  logic                       out_valid;
  logic                       out_ready;
  coord_t                     out_x;
  coord_t                     out_y;
  coord_t                     out_z;
  logic                       run_end;

  // predictor state: open path, its first and latest waypoint, step count
  vec_t                       path_first;
  vec_t                       path_prev;
  bit                         path_open;
  logic [STEP_W-1:0]          steps_reg;

  point_t                     due_points[$];  // points still owed by the block
  point_t                     seg_buf[$];     // points of the waypoint being planned
  row_t                       script[$];

  // idling controls, set by the sender; the receiver reads rx_idle_on and hold_requests
  bit                         tx_idle_on;
  bit                         rx_idle_on;
  int                         hold_requests;

  int                         fail_count;
  int                         n_waypoints;
  int                         n_paths;
  int                         n_checked;
  int                         n_cfg;
  int                         cycle_count;

  closed_path_linear_interpolator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .is_final    (is_final),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .run_end     (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero means one point, anything past the maximum clamps
  function automatic int points_per_segment(logic [STEP_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > MAX_STEPS) n = MAX_STEPS;
    return n;
  endfunction

  // one axis of point s out of n, quotient truncated toward zero
  function automatic coord_t lerp_axis(coord_t a, coord_t b, int s, int n);
    longint d;
    longint q;
    d = longint'(b) - longint'(a);
    q = (d * longint'(s)) / longint'(n);
    return coord_t'(longint'(a) + q);
  endfunction

  function automatic void add_segment(vec_t a, vec_t b, int n);
    point_t p;
    for (int s = 0; s < n; s++) begin
      p.x       = lerp_axis(a.x, b.x, s, n);
      p.y       = lerp_axis(a.y, b.y, s, n);
      p.z       = lerp_axis(a.z, b.z, s, n);
      p.run_end = 1'b0;
      seg_buf.insert(seg_buf.size(), p);
    end
  endfunction

  // works out the points one accepted waypoint causes and queues them
  function automatic void plan_waypoint(vec_t cur, logic fin, bit fixed, vec_t fixed_pt);
    int n;
    n = points_per_segment(steps_reg);
    seg_buf.delete();
    if (!path_open) begin
      path_first = cur;
      path_prev  = cur;
      // a lone final waypoint closes onto itself
      if (fin) add_segment(cur, cur, n);
      else path_open = 1'b1;
    end else begin
      add_segment(path_prev, cur, n);
      if (fin) add_segment(cur, path_first, n);
      path_prev = cur;
      if (fin) path_open = 1'b0;
    end
    if (seg_buf.size() > 0) seg_buf[seg_buf.size()-1].run_end = 1'b1;
    foreach (seg_buf[i]) begin
      if (fixed) begin
        seg_buf[i].x = fixed_pt.x;
        seg_buf[i].y = fixed_pt.y;
        seg_buf[i].z = fixed_pt.z;
      end
      due_points.insert(due_points.size(), seg_buf[i]);
    end
    if (fin) n_paths++;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void row_point(coord_t x, coord_t y, coord_t z, logic fin);
    row_t r;
    r.kind     = ROW_POINT;
    r.steps    = '0;
    r.pos      = '{x, y, z};
    r.fin      = fin;
    r.fixed    = 1'b0;
    r.fixed_pt = '0;
    script.insert(script.size(), r);
  endfunction

  function automatic void row_fixed(coord_t x, coord_t y, coord_t z, logic fin,
                                    coord_t ex, coord_t ey, coord_t ez);
    row_t r;
    r.kind     = ROW_POINT;
    r.steps    = '0;
    r.pos      = '{x, y, z};
    r.fin      = fin;
    r.fixed    = 1'b1;
    r.fixed_pt = '{ex, ey, ez};
    script.insert(script.size(), r);
  endfunction

  function automatic void row_steps(logic [STEP_W-1:0] v);
    row_t r;
    r.kind     = ROW_STEPS;
    r.steps    = v;
    r.pos      = '0;
    r.fin      = 1'b0;
    r.fixed    = 1'b0;
    r.fixed_pt = '0;
    script.insert(script.size(), r);
  endfunction

  // mostly small step counts, sometimes zero, mid-range, the maximum or oversized
  function automatic logic [STEP_W-1:0] pick_steps();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STEP_W'(MAX_STEPS);
      2:       return STEP_W'($urandom_range(MAX_STEPS + 1, 63));
      3:       return STEP_W'($urandom_range(9, MAX_STEPS - 1));
      default: return STEP_W'($urandom_range(1, 8));
    endcase
  endfunction

  // full range, extremes, small values, single bits, or a short hop from near
  function automatic coord_t pick_coord(coord_t near);
    case ($urandom_range(0, 9))
      0:       return CMAX;
      1:       return CMIN;
      2, 3, 4: return coord_t'($urandom);
      5, 6:    return coord_t'(int'($urandom_range(0, 8191)) - 4096);
      7:       return coord_t'(32'h1 << $urandom_range(0, 31));
      default: return near + coord_t'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  // offers one waypoint, with an optional gap first, and waits for its transfer
  task automatic send_waypoint(input vec_t pos, input logic fin, input bit fixed,
                               input vec_t fixed_pt);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= pos.x;
    pos_y    <= pos.y;
    pos_z    <= pos.z;
    is_final <= fin;
    do @(posedge clk); while (!in_ready);
    plan_waypoint(pos, fin, fixed, fixed_pt);
    n_waypoints++;
  endtask

  // stop offering, let every owed point come out, then pad with quiet cycles
  task automatic settle_block();
    in_valid <= 1'b0;
    while (due_points.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_steps(input logic [STEP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    steps_reg = v;
    n_cfg++;
  endtask

  function automatic void log_failure(string msg);
    if (fail_count < 10) $display("error: %s", msg);
    fail_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: directed script, then random paths in phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    vec_t cur;
    int   left;
    int   len;

    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    pos_x       <= '0;
    pos_y       <= '0;
    pos_z       <= '0;
    is_final    <= 1'b0;
    path_first  = '0;
    path_prev   = '0;
    path_open   = 1'b0;
    steps_reg   = STEPS_RESET;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    cur         = '0;

    // reset step count: a lone waypoint repeats itself
    row_fixed(32'sh0001_8000, 32'shfffd_c000, 32'sh0, 1'b1,
              32'sh0001_8000, 32'shfffd_c000, 32'sh0);
    // segments spanning the whole coordinate range both ways
    row_point(CMAX, CMIN, 32'sh0, 1'b0);
    row_point(CMIN, CMAX, -32'sh1, 1'b0);
    row_point(32'sh0, 32'sh0, CMAX, 1'b1);
    row_fixed(CMAX, CMAX, CMAX, 1'b1, CMAX, CMAX, CMAX);
    row_fixed(CMIN, CMIN, CMIN, 1'b1, CMIN, CMIN, CMIN);
    // zero steps behaves as one point per segment, the segment start
    row_steps('0);
    row_point(32'sh64, 32'shc8, 32'sh12c, 1'b0);
    row_fixed(-32'sh5, 32'sh7, CMIN, 1'b0, 32'sh64, 32'shc8, 32'sh12c);
    row_point(CMAX, -32'sh1, 32'sh1, 1'b1);
    // all ones clamps to the maximum: longest burst from one waypoint
    row_steps(6'h3f);
    row_point(CMIN, 32'sh0, CMAX, 1'b0);
    row_point(CMAX, 32'sh0, CMIN, 1'b1);
    row_steps(6'd1);
    row_fixed(32'sh7, 32'sh7, 32'sh7, 1'b1, 32'sh7, 32'sh7, 32'sh7);
    // maximum steps on tiny deltas: truncation toward zero on both signs
    row_steps(STEP_W'(MAX_STEPS));
    row_point(32'sh0, 32'sh0, 32'sh0, 1'b0);
    row_point(32'sh1, -32'sh1, 32'sh0001_0000, 1'b0);
    row_point(-32'sh3, 32'sh3, 32'sh5, 1'b1);
    // just past the maximum clamps; a path of repeated waypoints stays put
    row_steps(STEP_W'(MAX_STEPS + 1));
    row_point(32'sha, 32'sha, 32'sha, 1'b0);
    row_fixed(32'sha, 32'sha, 32'sha, 1'b0, 32'sha, 32'sha, 32'sha);
    row_fixed(32'sha, 32'sha, 32'sha, 1'b1, 32'sha, 32'sha, 32'sha);
    row_steps(6'd5);
    row_point(32'sh0, 32'sh0, 32'sh0, 1'b0);
    row_point(-32'sh7, 32'shd, -32'sh1, 1'b0);
    row_point(32'sh3, -32'sh9, 32'sh2, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_STEPS) begin
        settle_block();
        write_steps(script[i].steps);
      end else begin
        send_waypoint(script[i].pos, script[i].fin, script[i].fixed, script[i].fixed_pt);
      end
    end

    // random paths of 1 to 6 waypoints, a fresh step count per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      write_steps(pick_steps());
      // phase 1: sender keeps offering while the receiver holds off
      // last phase: no idling on either side
      tx_idle_on = (phase != 1) && (phase != PHASES - 1);
      rx_idle_on = (phase != PHASES - 1);
      if (phase == 1) hold_requests++;
      left = PHASE_ITEMS;
      while (left > 0) begin
        len = $urandom_range(1, 6);
        if (len > left) len = left;
        for (int k = 0; k < len; k++) begin
          cur.x = pick_coord(cur.x);
          cur.y = pick_coord(cur.y);
          cur.z = pick_coord(cur.z);
          send_waypoint(cur, k == len - 1, 1'b0, '0);
        end
        left -= len;
      end
    end

    in_valid <= 1'b0;
    while (due_points.size() != 0) @(posedge clk);
    repeat (END_PAD) @(posedge clk);

    $display("covered %0d waypoints in %0d closed paths, %0d points checked, %0d step writes",
             n_waypoints, n_paths, n_checked, n_cfg);
    $display("included full-range segments, zero and oversized step counts, lone waypoints");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!rx_idle_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        // start a burst of stalled cycles of random length
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each point transfer against the oldest owed point
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_points.size() == 0) begin
        log_failure($sformatf("unexpected point (%0d, %0d, %0d) run_end %0b",
                              out_x, out_y, out_z, run_end));
      end else begin
        want = due_points.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
            run_end !== want.run_end) begin
          log_failure($sformatf("point %0d: expected (%0d, %0d, %0d) end %0b, got (%0d, %0d, %0d) end %0b",
                                n_checked, want.x, want.y, want.z, want.run_end,
                                out_x, out_y, out_z, run_end));
        end
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d points still owed", cycle_count,
               due_points.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule
